// File: rtl/bgs_pkg.sv
`timescale 1ns / 1ps
package bgs_pkg;

	localparam int SAMPLE_BITS_DEF = 13;

	// fixed field widths
	localparam int MV_W      = 13;
	localparam int DDIV_W    = 8;
	localparam int LVL_W     = 12;
	localparam int PCT_W     = 7;
	localparam int CLS_W     = 2;
	localparam int PCT_NUM_W = 20;   // (mv span) * 100 fits here
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	localparam logic [MV_W-1:0]   FULL_RST  = 13'd4200;
	localparam logic [MV_W-1:0]   EMPTY_RST = 13'd3300;
	localparam logic [DDIV_W-1:0] DDIV_RST  = 8'd10;
	localparam logic [LVL_W-1:0]  THR_RST   = 12'd500;

	localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
	localparam logic [PCT_W-1:0] PCT_LOW_LIM  = 7'd20;
	localparam logic [PCT_W-1:0] PCT_HIGH_LIM = 7'd90;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_DIS  = 2'd1,
		MODE_CHG  = 2'd2
	} mode_t;

	typedef enum logic [CLS_W-1:0] {
		LVL_LOW  = 2'd0,
		LVL_MID  = 2'd1,
		LVL_HIGH = 2'd2
	} lvl_t;

	typedef enum logic [1:0] {
		REG_FULL  = 2'd0,
		REG_EMPTY = 2'd1,
		REG_DDIV  = 2'd2,
		REG_THR   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_PREP,
		ST_DIVB,
		ST_DIVP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MV_W-1:0]   full_mv;
		logic [MV_W-1:0]   empty_mv;
		logic [DDIV_W-1:0] decay_div;
		logic [LVL_W-1:0]  thr;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic calc;
		logic prep;
		logic div_start;
		logic div_pct;    // 1: percent division, 0: bias decay division
		logic bias_upd;
		logic pct_cap;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/bgs_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. quo is valid while done is high.
module bgs_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             bit_ok;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign bit_ok  = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= bit_ok ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], bit_ok};
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign quo  = quo_q;

endmodule

// File: rtl/bgs_dp.sv
`timescale 1ns / 1ps
module bgs_dp #(
	parameter int SAMPLE_BITS = bgs_pkg::SAMPLE_BITS_DEF,
	parameter int OUT_W       = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bgs_pkg::cfg_t               cfg,
	input  bgs_pkg::cmd_t               cmd,
	output bgs_pkg::sts_t               sts,
	input  logic [SAMPLE_BITS-1:0]      voltage_sample,
	input  logic [bgs_pkg::LVL_W-1:0]   charger_level,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [OUT_W-1:0]            m_tdata
);

	localparam int W      = SAMPLE_BITS;
	localparam int CW     = W + 2;
	localparam int MV_W   = bgs_pkg::MV_W;
	localparam int CMPW   = (W > MV_W) ? W : MV_W;
	localparam int NUM_W  = bgs_pkg::PCT_NUM_W;
	localparam int DIV_NW = (W > NUM_W) ? W : NUM_W;
	localparam int PCT_W  = bgs_pkg::PCT_W;
	localparam logic [W-1:0] SMAX = '1;

	// input and state
	logic [W-1:0]           v_q;
	logic                   chg_q;
	bgs_pkg::mode_t         mode_q;
	logic [W-1:0]           last_d_q;
	logic [W-1:0]           last_c_q;
	logic [W:0]             bias_q;      // two's complement
	logic                   trans_q;
	logic [W-1:0]           c_q;
	logic                   ge_full_q;
	logic                   le_empty_q;
	logic [NUM_W-1:0]       num_q;
	logic [PCT_W-1:0]       pct_q;
	logic                   m_valid_q;
	logic [OUT_W-1:0]       m_data_q;

	// correction step
	logic [W-1:0]           ld_eff, lc_eff, own_eff, other;
	logic                   trans;
	logic signed [CW-1:0]   c_raw, own_ext, c_clamp, c_pre;
	logic [W-1:0]           c_sat;
	logic [W:0]             bias_trans;

	always_comb begin
		ld_eff  = (last_d_q == '0) ? v_q : last_d_q;
		lc_eff  = (last_c_q == '0) ? v_q : last_c_q;
		own_eff = chg_q ? lc_eff : ld_eff;
		other   = chg_q ? last_d_q : last_c_q;
		trans   = chg_q ? (mode_q == bgs_pkg::MODE_DIS) : (mode_q == bgs_pkg::MODE_CHG);
		c_raw   = $signed({2'b00, v_q}) - $signed({bias_q[W], bias_q});
		own_ext = $signed({2'b00, own_eff});
		if (chg_q)
			c_clamp = (c_raw <= own_ext) ? own_ext : c_raw;
		else
			c_clamp = (c_raw >= own_ext) ? own_ext : c_raw;
		c_pre = trans ? $signed({2'b00, other}) : c_clamp;
		if (c_pre[CW-1])
			c_sat = '0;
		else if (c_pre > $signed({2'b00, SMAX}))
			c_sat = SMAX;
		else
			c_sat = c_pre[W-1:0];
		bias_trans = {1'b0, v_q} - {1'b0, other};
	end

	// percent mapping terms
	logic [CMPW-1:0]        c_ext, full_ext, empty_ext, diff;
	logic [MV_W-1:0]        span;

	assign c_ext     = CMPW'(c_q);
	assign full_ext  = CMPW'(cfg.full_mv);
	assign empty_ext = CMPW'(cfg.empty_mv);
	assign diff      = c_ext - empty_ext;
	assign span      = cfg.full_mv - cfg.empty_mv;

	// shared divider operands
	logic [W:0]                  bias_neg;
	logic [W-1:0]                bias_mag;
	logic [bgs_pkg::DDIV_W-1:0]  ddiv;
	logic [DIV_NW-1:0]           div_num;
	logic [MV_W-1:0]             div_den;
	logic                        div_done;
	logic [DIV_NW-1:0]           quo;
	logic [W:0]                  q_b;

	assign bias_neg = -bias_q;
	assign bias_mag = bias_q[W] ? bias_neg[W-1:0] : bias_q[W-1:0];
	assign ddiv     = (cfg.decay_div == '0) ? bgs_pkg::DDIV_W'(1) : cfg.decay_div;
	assign div_num  = cmd.div_pct ? DIV_NW'(num_q) : DIV_NW'(bias_mag);
	assign div_den  = cmd.div_pct ? span : MV_W'(ddiv);
	assign q_b      = {1'b0, quo[W-1:0]};

	bgs_div #(
		.NUM_W (DIV_NW),
		.DEN_W (MV_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= bgs_pkg::MODE_NONE;
			last_d_q <= '0;
			last_c_q <= '0;
			bias_q   <= '0;
		end else begin
			if (cmd.calc) begin
				if (chg_q) begin
					last_c_q <= c_sat;
					mode_q   <= bgs_pkg::MODE_CHG;
				end else begin
					last_d_q <= c_sat;
					mode_q   <= bgs_pkg::MODE_DIS;
				end
				if (trans)
					bias_q <= bias_trans;
			end
			// bias fades by bias / divisor, truncated toward zero
			if (cmd.bias_upd && !trans_q)
				bias_q <= bias_q[W] ? (bias_q + q_b) : (bias_q - q_b);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			v_q   <= voltage_sample;
			chg_q <= charger_level > cfg.thr;
		end
		if (cmd.calc) begin
			c_q     <= c_sat;
			trans_q <= trans;
		end
		if (cmd.prep) begin
			ge_full_q  <= c_ext >= full_ext;
			le_empty_q <= c_ext <= empty_ext;
			num_q      <= NUM_W'(diff[MV_W-1:0]) * NUM_W'(bgs_pkg::PCT_FULL);
		end
		if (cmd.pct_cap) begin
			if (ge_full_q)
				pct_q <= bgs_pkg::PCT_FULL;
			else if (le_empty_q)
				pct_q <= '0;
			else
				pct_q <= quo[PCT_W-1:0];
		end
	end

	// output register
	bgs_pkg::lvl_t cls;

	always_comb begin
		if (pct_q < bgs_pkg::PCT_LOW_LIM)
			cls = bgs_pkg::LVL_LOW;
		else if (pct_q > bgs_pkg::PCT_HIGH_LIM)
			cls = bgs_pkg::LVL_HIGH;
		else
			cls = bgs_pkg::LVL_MID;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			m_data_q <= OUT_W'({chg_q, cls, pct_q, c_q});
	end

	assign m_tvalid     = m_valid_q;
	assign m_tdata      = m_data_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !m_valid_q || m_tready;

endmodule

// File: rtl/bgs_ctrl.sv
`timescale 1ns / 1ps
module bgs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  bgs_pkg::sts_t sts,
	output bgs_pkg::cmd_t cmd
);

	bgs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bgs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			bgs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = bgs_pkg::ST_CALC;
				end
			end
			bgs_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = bgs_pkg::ST_PREP;
			end
			bgs_pkg::ST_PREP: begin
				cmd.prep      = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = bgs_pkg::ST_DIVB;
			end
			bgs_pkg::ST_DIVB: begin
				if (sts.div_done) begin
					cmd.bias_upd  = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_pct   = 1'b1;
					state_d       = bgs_pkg::ST_DIVP;
				end
			end
			bgs_pkg::ST_DIVP: begin
				cmd.div_pct = 1'b1;
				if (sts.div_done) begin
					cmd.pct_cap = 1'b1;
					state_d     = bgs_pkg::ST_DONE;
				end
			end
			bgs_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = bgs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bgs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/battery_gauge_smoother.sv
`timescale 1ns / 1ps
// One shared 20-step divider runs twice per sample (bias decay, then percent).
// A new sample is taken only after the previous result enters the output register;
//   it is taken while that finished result still waits there for the consumer.
// Reset: arst_n clears charge mode, last values, bias and control state, and loads
//   the configuration registers with their defaults.
module battery_gauge_smoother #(
	parameter int SAMPLE_BITS = bgs_pkg::SAMPLE_BITS_DEF,
	localparam int S_TDATA_W = ((SAMPLE_BITS + bgs_pkg::LVL_W + 7) / 8) * 8,
	localparam int M_TDATA_W =
		((SAMPLE_BITS + bgs_pkg::PCT_W + bgs_pkg::CLS_W + 1 + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// voltage_sample, charger_level
	input  logic [S_TDATA_W-1:0]        s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// corrected_mv, percent, level_class, charging
	output logic [M_TDATA_W-1:0]        m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bgs_pkg::APB_AW-1:0]  paddr,
	input  logic [bgs_pkg::APB_DW-1:0]  pwdata,
	output logic [bgs_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	bgs_pkg::cfg_t     cfg_q;
	bgs_pkg::reg_idx_t reg_idx;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = bgs_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_mv   <= bgs_pkg::FULL_RST;
			cfg_q.empty_mv  <= bgs_pkg::EMPTY_RST;
			cfg_q.decay_div <= bgs_pkg::DDIV_RST;
			cfg_q.thr       <= bgs_pkg::THR_RST;
		end else if (wr_en) begin
			case (reg_idx)
				bgs_pkg::REG_FULL:  cfg_q.full_mv   <= pwdata[bgs_pkg::MV_W-1:0];
				bgs_pkg::REG_EMPTY: cfg_q.empty_mv  <= pwdata[bgs_pkg::MV_W-1:0];
				bgs_pkg::REG_DDIV:  cfg_q.decay_div <= pwdata[bgs_pkg::DDIV_W-1:0];
				bgs_pkg::REG_THR:   cfg_q.thr       <= pwdata[bgs_pkg::LVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bgs_pkg::REG_FULL:  prdata = bgs_pkg::APB_DW'(cfg_q.full_mv);
			bgs_pkg::REG_EMPTY: prdata = bgs_pkg::APB_DW'(cfg_q.empty_mv);
			bgs_pkg::REG_DDIV:  prdata = bgs_pkg::APB_DW'(cfg_q.decay_div);
			bgs_pkg::REG_THR:   prdata = bgs_pkg::APB_DW'(cfg_q.thr);
			default:            prdata = '0;
		endcase
	end

	bgs_pkg::cmd_t cmd;
	bgs_pkg::sts_t sts;

	bgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bgs_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.OUT_W       (M_TDATA_W)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.sts            (sts),
		.voltage_sample (s_tdata[SAMPLE_BITS-1:0]),
		.charger_level  (s_tdata[SAMPLE_BITS +: bgs_pkg::LVL_W]),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

endmodule

// File: tb/battery_gauge_smoother_tb.sv
`timescale 1ns / 1ps
module battery_gauge_smoother_tb;
	import bgs_pkg::*;

	localparam int S_W         = 32;  // 13 + 12 bits, padded to bytes
	localparam int M_W         = 24;  // 13 + 7 + 2 + 1 bits, padded to bytes
	localparam int MV_MAX      = (1 << MV_W) - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 60;

	typedef struct {
		logic [MV_W-1:0]  mv;
		logic [PCT_W-1:0] pct;
		lvl_t             cls;
		logic             chg;
	} gauge_out_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	// voltage_sample [12:0], charger_level [24:13], zero pad [31:25]
	logic [S_W-1:0]   s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	// corrected_mv [12:0], percent [19:13], level_class [21:20], charging [22], pad [23]
	logic [M_W-1:0]   m_tdata;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic             pready;

	battery_gauge_smoother dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// shadow configuration
	logic [MV_W-1:0]   cfg_full;
	logic [MV_W-1:0]   cfg_empty;
	logic [DDIV_W-1:0] cfg_div;
	logic [LVL_W-1:0]  cfg_thr;

	// shadow gauge state
	mode_t seen_mode;
	int    dis_hold_mv;
	int    chg_hold_mv;
	int    jump_bias;

	gauge_out_t pending_readings[$];

	int  errors;
	int  samples_sent;
	int  readings_checked;
	int  settings_used;
	int  reg_reads;
	int  cycle_cnt;
	int  stall_left;
	bit  no_idle;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Expected gauge output for one sample; advances the shadow state.
	function automatic gauge_out_t smooth_reading(input logic [MV_W-1:0] v_in,
		input logic [LVL_W-1:0] lvl);
		int v, c, d, pct, fs, em;
		logic chg;
		gauge_out_t r;
		v   = int'(v_in);
		chg = lvl > cfg_thr;
		d   = (cfg_div == '0) ? 1 : int'(cfg_div);
		if (!chg) begin
			if (dis_hold_mv == 0)
				dis_hold_mv = v;
			if (seen_mode == MODE_CHG) begin
				jump_bias = v - chg_hold_mv;
				c = v - jump_bias;
			end else begin
				c = v - jump_bias;
				jump_bias = jump_bias - jump_bias / d;
				if (c >= dis_hold_mv)
					c = dis_hold_mv;
			end
		end else begin
			if (chg_hold_mv == 0)
				chg_hold_mv = v;
			if (seen_mode == MODE_DIS) begin
				jump_bias = v - dis_hold_mv;
				c = v - jump_bias;
			end else begin
				c = v - jump_bias;
				jump_bias = jump_bias - jump_bias / d;
				if (c <= chg_hold_mv)
					c = chg_hold_mv;
			end
		end
		if (c < 0)
			c = 0;
		else if (c > MV_MAX)
			c = MV_MAX;
		if (chg) begin
			chg_hold_mv = c;
			seen_mode   = MODE_CHG;
		end else begin
			dis_hold_mv = c;
			seen_mode   = MODE_DIS;
		end
		fs = int'(cfg_full);
		em = int'(cfg_empty);
		if (c >= fs)
			pct = int'(PCT_FULL);
		else if (c <= em)
			pct = 0;
		else
			pct = (c - em) * 100 / (fs - em);
		r.mv  = c[MV_W-1:0];
		r.pct = pct[PCT_W-1:0];
		if (pct < PCT_LOW_LIM)
			r.cls = LVL_LOW;
		else if (pct > PCT_HIGH_LIM)
			r.cls = LVL_HIGH;
		else
			r.cls = LVL_MID;
		r.chg = chg;
		return r;
	endfunction

	function automatic logic [APB_DW-1:0] shadow_value(input reg_idx_t idx);
		case (idx)
			REG_FULL:  return APB_DW'(cfg_full);
			REG_EMPTY: return APB_DW'(cfg_empty);
			REG_DDIV:  return APB_DW'(cfg_div);
			default:   return APB_DW'(cfg_thr);
		endcase
	endfunction

	function automatic void report_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_FULL:  cfg_full  = val[MV_W-1:0];
			REG_EMPTY: cfg_empty = val[MV_W-1:0];
			REG_DDIV:  cfg_div   = val[DDIV_W-1:0];
			default:   cfg_thr   = val[LVL_W-1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic reg_read_check(input reg_idx_t idx);
		logic [APB_DW-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		reg_reads++;
		if (got !== shadow_value(idx)) begin
			$display("%0t ns: register %s read mismatch, expected %0d, actual %0d",
				$time, idx.name(), shadow_value(idx), got);
			errors++;
		end
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [MV_W-1:0] v, input logic [LVL_W-1:0] lvl);
		int gap;
		s_tdata  <= {{(S_W - MV_W - LVL_W){1'b0}}, lvl, v};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_readings.push_back(smooth_reading(v, lvl));
		samples_sent++;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every outstanding reading.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input int full, input int empty, input int div, input int thr);
		drain();
		reg_write(REG_FULL, full);
		reg_write(REG_EMPTY, empty);
		reg_write(REG_DDIV, div);
		reg_write(REG_THR, thr);
		settings_used++;
	endtask

	// Mostly realistic charge/discharge runs with random content, some raw noise.
	task automatic run_sessions(input int n);
		int done_cnt, len, v, lvl, step;
		bit charging;
		done_cnt = 0;
		while (done_cnt < n) begin
			if ($urandom_range(0, 9) < 2) begin
				len = $urandom_range(1, 4);
				repeat (len) begin
					send_sample(MV_W'($urandom_range(0, MV_MAX)),
						LVL_W'($urandom_range(0, 4095)));
					done_cnt++;
				end
			end else begin
				charging = 1'($urandom_range(0, 1));
				len = $urandom_range(1, 20);
				if ($urandom_range(0, 3) == 0)
					v = $urandom_range(0, MV_MAX);
				else
					v = $urandom_range(2800, 4400);
				repeat (len) begin
					step = $urandom_range(0, 15);
					v = v + (charging ? step : -step) + $urandom_range(0, 40) - 20;
					if (v < 0)
						v = 0;
					else if (v > MV_MAX)
						v = MV_MAX;
					if (charging && cfg_thr != '1)
						lvl = $urandom_range(int'(cfg_thr) + 1, 4095);
					else if (!charging)
						lvl = $urandom_range(0, int'(cfg_thr));
					else
						lvl = $urandom_range(0, 4095);
					send_sample(MV_W'(v), LVL_W'(lvl));
					done_cnt++;
				end
			end
		end
	endtask

	task automatic test_register_access();
		reg_idx_t all_regs[4] = '{REG_FULL, REG_EMPTY, REG_DDIV, REG_THR};
		foreach (all_regs[i])
			reg_read_check(all_regs[i]);
		foreach (all_regs[i]) begin
			reg_write(all_regs[i], $urandom());
			reg_read_check(all_regs[i]);
			reg_write(all_regs[i], '1);
			reg_read_check(all_regs[i]);
		end
		set_config(int'(FULL_RST), int'(EMPTY_RST), int'(DDIV_RST), int'(THR_RST));
		foreach (all_regs[i])
			reg_read_check(all_regs[i]);
	endtask

	// First sample, seeding, both transitions, clamps, threshold edges,
	// saturation at zero and at full scale, field extremes.
	task automatic test_directed_sequence();
		int dir_v[22] = '{3900, 3800, 3850, 4000, 4050, 4010, 4100, 4100, 4090, 8191, 8191,
			0, 0, 3000, 8191, 0, 8191, 4200, 3300, 4095, 4096, 8191};
		int dir_l[22] = '{0, 0, 0, 4095, 4095, 4095, 501, 500, 0, 4095, 4095,
			0, 0, 0, 0, 4095, 4095, 0, 0, 2048, 2047, 4095};
		foreach (dir_v[i])
			send_sample(MV_W'(dir_v[i]), LVL_W'(dir_l[i]));
		drain();
	endtask

	task automatic test_random_defaults();
		no_idle = 1'b1;
		run_sessions(40);
		no_idle = 1'b0;
		run_sessions(80);
	endtask

	task automatic test_wide_scale();
		set_config(MV_MAX, 0, 1, 0);
		run_sessions(90);
	endtask

	task automatic test_inverted_scale();
		set_config(3300, 4200, 255, 4095);
		run_sessions(35);
		set_config(0, MV_MAX, 255, 2048);
		run_sessions(35);
	endtask

	task automatic test_zero_divisor();
		set_config(4200, 3300, 0, 500);
		run_sessions(70);
	endtask

	task automatic test_random_configs();
		int a, b;
		repeat (3) begin
			a = $urandom_range(0, MV_MAX);
			b = $urandom_range(0, MV_MAX);
			if ($urandom_range(0, 3) != 0 && a < b)
				set_config(b, a, $urandom_range(0, 255), $urandom_range(0, 4095));
			else
				set_config(a, b, $urandom_range(0, 255), $urandom_range(0, 4095));
			run_sessions(30);
		end
	endtask

	// Result checker and output-side backpressure.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_readings.size() == 0) begin
				$display("%0t ns: unexpected reading, expected none, actual 0x%0h",
					$time, m_tdata);
				errors++;
			end else begin
				gauge_out_t exp_r;
				exp_r = pending_readings.pop_front();
				report_field("corrected_mv", int'(exp_r.mv), int'(m_tdata[12:0]));
				report_field("percent", int'(exp_r.pct), int'(m_tdata[19:13]));
				report_field("level_class", int'(exp_r.cls), int'(m_tdata[21:20]));
				report_field("charging", int'(exp_r.chg), int'(m_tdata[22]));
				readings_checked++;
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			stall_left = idle_len();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d readings outstanding",
				cycle_cnt, pending_readings.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		errors     = 0;
		samples_sent     = 0;
		readings_checked = 0;
		settings_used    = 1;
		reg_reads  = 0;
		cycle_cnt  = 0;
		stall_left = 0;
		no_idle    = 1'b0;
		cfg_full   = FULL_RST;
		cfg_empty  = EMPTY_RST;
		cfg_div    = DDIV_RST;
		cfg_thr    = THR_RST;
		seen_mode  = MODE_NONE;
		dis_hold_mv = 0;
		chg_hold_mv = 0;
		jump_bias   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_sequence();
		test_register_access();
		test_random_defaults();
		test_wide_scale();
		test_inverted_scale();
		test_zero_divisor();
		test_random_configs();

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d voltage samples under %0d gauge settings; %0d readings checked,",
			samples_sent, settings_used, readings_checked);
		$display("%0d register reads compared.", reg_reads);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
rtl/bgs_pkg.sv
rtl/bgs_div.sv
rtl/bgs_dp.sv
rtl/bgs_ctrl.sv
rtl/battery_gauge_smoother.sv
tb/battery_gauge_smoother_tb.sv
